/* rtl/core/tbsm_pkg.sv */
// Shared constants, link type and saturating increment for the tainted
// branch site monitor. No dependencies.
`default_nettype none

package tbsm_pkg;

    localparam int SITE_ENTRIES = 32;
    localparam int PC_BITS      = 48;
    localparam int COUNT_BITS   = 32;
    localparam int SLOT_W       = (SITE_ENTRIES > 1) ? $clog2(SITE_ENTRIES) : 1;
    localparam int FILL_W       = $clog2(SITE_ENTRIES + 1);

    localparam logic OP_FLAG_WRITE = 1'b0;
    localparam logic OP_BRANCH     = 1'b1;

    // Result of the site lookup as it travels down the row of cells
    typedef struct packed {
        logic                  found;
        logic [SLOT_W-1:0]     slot;
        logic [COUNT_BITS-1:0] hits;
    } t_site_link;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (&v) ? v : v + COUNT_BITS'(1);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/tainted_branch_site_monitor_core.sv */
// Tainted branch site monitor: flag taint tracking, counters, control and
// the row of site cells. Depends on tbsm_pkg and tbsm_site_cell.
//
// Input channel (i_in_valid / o_in_stall) takes one trace word: operation,
// pc and source taint mask. Output channel (o_out_valid / i_out_stall)
// returns exactly one result word per input word, in order.
// A word passes through the accept cycle, where every site cell compares
// its stored pc against the incoming pc, then a commit cycle, where for a
// tainted branch the matching cell (or the next free one) is updated, and
// the result is loaded into the output register. o_out_valid rises at the
// commit edge; no new word is taken until the previous word has committed.
// While a result waits in the output register the next word is still taken;
// its commit waits until the output register is freed, holding o_in_stall.
// Reset (synchronous, active low) clears the flag taint, defining pc,
// counters and the table fill; the table contents themselves are not
// cleared, slots at or above the fill count are never consulted.
// All counters saturate.
`default_nettype none

module tainted_branch_site_monitor_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_operation,
    input  wire logic [tbsm_pkg::PC_BITS-1:0]      i_pc,
    input  wire logic [3:0]                        i_src_taint_mask,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic                                   o_leak,
    output logic [tbsm_pkg::PC_BITS-1:0]           o_defining_pc,
    output logic [tbsm_pkg::SLOT_W-1:0]            o_site_slot,
    output logic                                   o_site_recorded,
    output logic [tbsm_pkg::COUNT_BITS-1:0]        o_site_hits,
    output logic [tbsm_pkg::COUNT_BITS-1:0]        o_branches_seen,
    output logic [tbsm_pkg::COUNT_BITS-1:0]        o_tainted_branches,
    output logic [tbsm_pkg::COUNT_BITS-1:0]        o_flag_wr_seen,
    output logic [tbsm_pkg::FILL_W-1:0]            o_sites_in_use
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOOK = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic                            r_op;
    logic [tbsm_pkg::PC_BITS-1:0]    r_pc;
    logic                            r_any_taint;
    logic                            r_flags_tainted;
    logic [tbsm_pkg::PC_BITS-1:0]    r_def_pc;
    logic [tbsm_pkg::COUNT_BITS-1:0] r_branch_cnt;
    logic [tbsm_pkg::COUNT_BITS-1:0] r_tainted_cnt;
    logic [tbsm_pkg::COUNT_BITS-1:0] r_flag_cnt;
    logic [tbsm_pkg::FILL_W-1:0]     r_fill;

    logic                            w_accept;
    logic                            w_commit;
    logic                            w_leak;
    logic                            w_full;
    logic                            w_record;
    logic                            w_alloc_any;
    logic [tbsm_pkg::SITE_ENTRIES-1:0] w_occupied;
    logic [tbsm_pkg::SITE_ENTRIES-1:0] w_alloc;
    tbsm_pkg::t_site_link            w_link [tbsm_pkg::SITE_ENTRIES+1];

    logic                            n_flags_tainted;
    logic [tbsm_pkg::PC_BITS-1:0]    n_def_pc;
    logic [tbsm_pkg::COUNT_BITS-1:0] n_branch_cnt;
    logic [tbsm_pkg::COUNT_BITS-1:0] n_tainted_cnt;
    logic [tbsm_pkg::COUNT_BITS-1:0] n_flag_cnt;
    logic [tbsm_pkg::FILL_W-1:0]     n_fill;
    logic [tbsm_pkg::SLOT_W-1:0]     n_slot;
    logic [tbsm_pkg::COUNT_BITS-1:0] n_hits;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_commit   = (r_state == S_LOOK) && (!o_out_valid || !i_out_stall);

    assign w_leak      = (r_op == tbsm_pkg::OP_BRANCH) && r_flags_tainted;
    assign w_full      = (r_fill == tbsm_pkg::FILL_W'(tbsm_pkg::SITE_ENTRIES));
    assign w_alloc_any = w_commit && w_leak && !w_link[tbsm_pkg::SITE_ENTRIES].found
                         && !w_full;
    assign w_record    = w_leak && (w_link[tbsm_pkg::SITE_ENTRIES].found || !w_full);

    assign w_link[0] = '0;

    for (genvar g = 0; g < tbsm_pkg::SITE_ENTRIES; g++) begin : g_cell
        assign w_occupied[g] = (tbsm_pkg::FILL_W'(g) < r_fill);
        assign w_alloc[g]    = w_alloc_any && (r_fill == tbsm_pkg::FILL_W'(g));

        tbsm_site_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_index    (tbsm_pkg::SLOT_W'(g)),
            .i_cmp_en   (w_accept),
            .i_cmp_pc   (i_pc),
            .i_occupied (w_occupied[g]),
            .i_update   (w_commit && w_leak),
            .i_alloc    (w_alloc[g]),
            .i_wr_pc    (r_pc),
            .i_link     (w_link[g]),
            .o_link     (w_link[g+1])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_LOOK;
            end
            S_LOOK: begin
                if (w_commit) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_flags_tainted = r_flags_tainted;
        n_def_pc        = r_def_pc;
        n_branch_cnt    = r_branch_cnt;
        n_tainted_cnt   = r_tainted_cnt;
        n_flag_cnt      = r_flag_cnt;
        n_fill          = r_fill;
        n_slot          = '0;
        n_hits          = '0;
        if (r_op == tbsm_pkg::OP_FLAG_WRITE) begin
            n_flags_tainted = r_any_taint;
            n_def_pc        = r_pc;
            n_flag_cnt      = tbsm_pkg::sat_inc(r_flag_cnt);
        end else begin
            n_branch_cnt = tbsm_pkg::sat_inc(r_branch_cnt);
            if (w_leak) begin
                n_tainted_cnt = tbsm_pkg::sat_inc(r_tainted_cnt);
                if (w_link[tbsm_pkg::SITE_ENTRIES].found) begin
                    n_slot = w_link[tbsm_pkg::SITE_ENTRIES].slot;
                    n_hits = w_link[tbsm_pkg::SITE_ENTRIES].hits;
                end else if (!w_full) begin
                    n_slot = r_fill[tbsm_pkg::SLOT_W-1:0];
                    n_hits = tbsm_pkg::COUNT_BITS'(1);
                    n_fill = r_fill + tbsm_pkg::FILL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            o_out_valid     <= 1'b0;
            r_flags_tainted <= 1'b0;
            r_def_pc        <= '0;
            r_branch_cnt    <= '0;
            r_tainted_cnt   <= '0;
            r_flag_cnt      <= '0;
            r_fill          <= '0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                o_out_valid     <= 1'b1;
                r_flags_tainted <= n_flags_tainted;
                r_def_pc        <= n_def_pc;
                r_branch_cnt    <= n_branch_cnt;
                r_tainted_cnt   <= n_tainted_cnt;
                r_flag_cnt      <= n_flag_cnt;
                r_fill          <= n_fill;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // captured word and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op        <= i_operation;
            r_pc        <= i_pc;
            r_any_taint <= |i_src_taint_mask;
        end
        if (w_commit) begin
            o_leak             <= w_leak;
            o_defining_pc      <= n_def_pc;
            o_site_slot        <= n_slot;
            o_site_recorded    <= w_record;
            o_site_hits        <= n_hits;
            o_branches_seen    <= n_branch_cnt;
            o_tainted_branches <= n_tainted_cnt;
            o_flag_wr_seen     <= n_flag_cnt;
            o_sites_in_use     <= n_fill;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tbsm_site_cell.sv */
// One slot of the site table: stored pc, hit count and match flag.
// Depends on tbsm_pkg; cells are chained through t_site_link.
`default_nettype none

module tbsm_site_cell (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [tbsm_pkg::SLOT_W-1:0]     i_index,
    input  wire logic                            i_cmp_en,
    input  wire logic [tbsm_pkg::PC_BITS-1:0]    i_cmp_pc,
    input  wire logic                            i_occupied,
    input  wire logic                            i_update,
    input  wire logic                            i_alloc,
    input  wire logic [tbsm_pkg::PC_BITS-1:0]    i_wr_pc,
    input  wire tbsm_pkg::t_site_link            i_link,
    output tbsm_pkg::t_site_link                 o_link
);

    logic [tbsm_pkg::PC_BITS-1:0]    r_addr;
    logic [tbsm_pkg::COUNT_BITS-1:0] r_count;
    logic                            r_match;
    logic [tbsm_pkg::COUNT_BITS-1:0] w_count_inc;

    assign w_count_inc = tbsm_pkg::sat_inc(r_count);

    // match is taken when the word is accepted; fill cannot move before use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_cmp_en) begin
            r_match <= i_occupied && (r_addr == i_cmp_pc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_alloc) begin
            r_addr  <= i_wr_pc;
            r_count <= tbsm_pkg::COUNT_BITS'(1);
        end else if (i_update && r_match) begin
            r_count <= w_count_inc;
        end
    end

    // at most one cell matches, so the chain merges by OR
    always_comb begin
        o_link.found = i_link.found | r_match;
        o_link.slot  = i_link.slot | (r_match ? i_index : '0);
        o_link.hits  = i_link.hits | (r_match ? w_count_inc : '0);
    end

endmodule

`default_nettype wire
